### design/apls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO LBA28 sequencer package
// Shared codes, constants and the job descriptor passed from the front part
// to the back part through the job queue.
// ----------------------------------------------------------------------------
package apls_pkg;

    localparam int unsigned SECTOR_WORDS  = 256;
    localparam int unsigned DUMMY_READS   = 4;
    localparam int unsigned BUDGET_W      = 20;
    localparam int unsigned WORD_CNT_W    = 9;
    localparam logic [19:0] BUDGET_RESET  = 20'd100000;

    localparam logic [2:0] ACT_INIT       = 3'd0;
    localparam logic [2:0] ACT_READ       = 3'd1;
    localparam logic [2:0] ACT_WRITE      = 3'd2;
    localparam logic [2:0] ACT_REPLY      = 3'd3;
    localparam logic [2:0] ACT_HOST_WORD  = 3'd4;

    localparam logic [2:0] KIND_BYTE_WR   = 3'd0;
    localparam logic [2:0] KIND_WORD_WR   = 3'd1;
    localparam logic [2:0] KIND_BYTE_RD   = 3'd2;
    localparam logic [2:0] KIND_WORD_RD   = 3'd3;
    localparam logic [2:0] KIND_DELAY     = 3'd4;
    localparam logic [2:0] KIND_HOST      = 3'd5;
    localparam logic [2:0] KIND_DONE      = 3'd6;
    localparam logic [2:0] KIND_DATA_REQ  = 3'd7;

    localparam logic [2:0] PORT_NONE      = 3'd0;
    localparam logic [2:0] PORT_COUNT     = 3'd2;
    localparam logic [2:0] PORT_LBA_LO    = 3'd3;
    localparam logic [2:0] PORT_LBA_MID   = 3'd4;
    localparam logic [2:0] PORT_LBA_HI    = 3'd5;
    localparam logic [2:0] PORT_DRIVE     = 3'd6;
    localparam logic [2:0] PORT_CMD       = 3'd7;

    localparam logic [7:0] DRIVE_BASE     = 8'hE0;
    localparam logic [7:0] CMD_IDENTIFY   = 8'hEC;
    localparam logic [7:0] CMD_READ       = 8'h20;
    localparam logic [7:0] CMD_WRITE      = 8'h30;
    localparam logic [7:0] CMD_FLUSH      = 8'hE7;

    localparam logic [7:0] ST_BSY         = 8'h80;
    localparam logic [7:0] ST_DF          = 8'h20;
    localparam logic [7:0] ST_DRQ         = 8'h08;
    localparam logic [7:0] ST_ERR         = 8'h01;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_FIRST,
        PH_DUMMY,
        PH_POLL,
        PH_IDWORDS,
        PH_RDWORDS,
        PH_WRWORDS
    } phase_t;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_READ,
        OP_WRITE,
        OP_FLUSH
    } op_t;

    typedef enum logic [1:0] {
        JOB_SINGLE,
        JOB_ISSUE,
        JOB_PAIR,
        JOB_FLUSH
    } job_kind_t;

    typedef struct packed {
        job_kind_t   jtype;
        logic [2:0]  kind;
        logic [2:0]  kind2;
        logic [2:0]  port;
        logic [15:0] value;
        logic        ok;
        logic [27:0] lba;
        logic        ready;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

    function automatic job_t mk_single(input logic [2:0] kind, input logic [2:0] port,
                                       input logic [15:0] value, input logic ok);
        job_t j;
        j       = '0;
        j.jtype = JOB_SINGLE;
        j.kind  = kind;
        j.port  = port;
        j.value = value;
        j.ok    = ok;
        return j;
    endfunction

endpackage

### design/apls_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO LBA28 sequencer front part
// Accepts commands, bus replies and host words, runs the protocol state and
// turns each accepted item into at most one job for the back part.
// ----------------------------------------------------------------------------
module apls_front
    import apls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [19:0] cfg_wdata,
    input  logic        accept,
    input  logic [2:0]  action,
    input  logic [27:0] lba,
    input  logic [15:0] data_in,
    output logic        job_valid,
    output job_t        job
);

    phase_t                  phase_reg, phase_next;
    op_t                     op_reg, op_next;
    logic                    ready_flag_reg, ready_flag_next;
    logic                    need_drq_reg, need_drq_next;
    logic [BUDGET_W-1:0]     poll_count_reg, poll_count_next;
    logic [BUDGET_W-1:0]     poll_budget_reg;
    logic [2:0]              dummy_count_reg, dummy_count_next;
    logic [WORD_CNT_W-1:0]   word_count_reg, word_count_next;

    logic [7:0]              status;
    logic [2:0]              dummy_inc;
    logic [BUDGET_W-1:0]     poll_inc;
    logic [BUDGET_W-1:0]     poll_check;
    logic [WORD_CNT_W-1:0]   word_inc;
    logic                    budget_hit;
    logic                    words_done;
    logic                    do_try;
    logic                    do_poll_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            op_reg          <= OP_INIT;
            ready_flag_reg  <= 1'b0;
            need_drq_reg    <= 1'b0;
            poll_count_reg  <= '0;
            dummy_count_reg <= '0;
            word_count_reg  <= '0;
            poll_budget_reg <= BUDGET_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            op_reg          <= op_next;
            ready_flag_reg  <= ready_flag_next;
            need_drq_reg    <= need_drq_next;
            poll_count_reg  <= poll_count_next;
            dummy_count_reg <= dummy_count_next;
            word_count_reg  <= word_count_next;
            if (cfg_wen)
            begin
                poll_budget_reg <= cfg_wdata;
            end
        end
    end

    assign status     = data_in[7:0];
    assign dummy_inc  = dummy_count_reg + 3'd1;
    assign poll_inc   = poll_count_reg + 1'b1;
    assign word_inc   = word_count_reg + 1'b1;
    assign poll_check = (phase_reg == PH_POLL) ? poll_inc : poll_count_reg;
    assign budget_hit = (poll_check >= poll_budget_reg);
    assign words_done = (word_inc >= WORD_CNT_W'(SECTOR_WORDS));

    always_comb
    begin
        phase_next       = phase_reg;
        op_next          = op_reg;
        ready_flag_next  = ready_flag_reg;
        need_drq_next    = need_drq_reg;
        poll_count_next  = poll_count_reg;
        dummy_count_next = dummy_count_reg;
        word_count_next  = word_count_reg;
        job_valid        = 1'b0;
        job              = '0;
        do_try           = 1'b0;
        do_poll_ok       = 1'b0;

        if (accept)
        begin
            unique case (action)
                ACT_INIT, ACT_READ, ACT_WRITE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        job_valid = 1'b1;
                        if (action == ACT_INIT)
                        begin
                            ready_flag_next = 1'b0;
                            op_next         = OP_INIT;
                            job             = '0;
                            job.jtype       = JOB_ISSUE;
                            job.value       = {8'd0, CMD_IDENTIFY};
                            phase_next      = PH_FIRST;
                        end
                        else if (!ready_flag_reg)
                        begin
                            job = mk_single(KIND_DONE, PORT_NONE, 16'd0, 1'b0);
                        end
                        else
                        begin
                            op_next          = (action == ACT_READ) ? OP_READ : OP_WRITE;
                            job              = '0;
                            job.jtype        = JOB_ISSUE;
                            job.lba          = lba;
                            job.ok           = 1'b1;
                            job.value        = {8'd0, (action == ACT_READ) ? CMD_READ : CMD_WRITE};
                            need_drq_next    = 1'b1;
                            dummy_count_next = '0;
                            poll_count_next  = '0;
                            phase_next       = PH_DUMMY;
                        end
                    end
                end
                ACT_REPLY:
                begin
                    unique case (phase_reg)
                        PH_FIRST:
                        begin
                            job_valid = 1'b1;
                            if (status == 8'd0)
                            begin
                                phase_next = PH_IDLE;
                                job        = mk_single(KIND_DONE, PORT_NONE, 16'd0, 1'b0);
                            end
                            else
                            begin
                                need_drq_next    = 1'b1;
                                dummy_count_next = '0;
                                poll_count_next  = '0;
                                phase_next       = PH_DUMMY;
                                job = mk_single(KIND_BYTE_RD, PORT_CMD, 16'd0, 1'b0);
                            end
                        end
                        PH_DUMMY:
                        begin
                            job_valid        = 1'b1;
                            dummy_count_next = dummy_inc;
                            if (dummy_inc < 3'(DUMMY_READS))
                            begin
                                job = mk_single(KIND_BYTE_RD, PORT_CMD, 16'd0, 1'b0);
                            end
                            else
                            begin
                                do_try = 1'b1;
                            end
                        end
                        PH_POLL:
                        begin
                            job_valid       = 1'b1;
                            poll_count_next = poll_inc;
                            if ((status & ST_BSY) != 8'd0)
                            begin
                                do_try = 1'b1;
                            end
                            else if ((status & (ST_ERR | ST_DF)) != 8'd0)
                            begin
                                phase_next = PH_IDLE;
                                job        = mk_single(KIND_DONE, PORT_NONE, 16'd0, 1'b0);
                            end
                            else if (!need_drq_reg || ((status & ST_DRQ) != 8'd0))
                            begin
                                do_poll_ok = 1'b1;
                            end
                            else
                            begin
                                do_try = 1'b1;
                            end
                        end
                        PH_IDWORDS:
                        begin
                            job_valid       = 1'b1;
                            word_count_next = word_inc;
                            if (words_done)
                            begin
                                ready_flag_next = 1'b1;
                                phase_next      = PH_IDLE;
                                job = mk_single(KIND_DONE, PORT_NONE, 16'd0, 1'b1);
                            end
                            else
                            begin
                                job = mk_single(KIND_WORD_RD, PORT_NONE, 16'd0, 1'b0);
                            end
                        end
                        PH_RDWORDS:
                        begin
                            job_valid       = 1'b1;
                            word_count_next = word_inc;
                            job             = '0;
                            job.jtype       = JOB_PAIR;
                            job.kind        = KIND_HOST;
                            job.value       = data_in;
                            if (words_done)
                            begin
                                phase_next = PH_IDLE;
                                job.kind2  = KIND_DONE;
                                job.ok     = 1'b1;
                            end
                            else
                            begin
                                job.kind2 = KIND_WORD_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ACT_HOST_WORD:
                begin
                    if (phase_reg == PH_WRWORDS)
                    begin
                        job_valid       = 1'b1;
                        word_count_next = word_inc;
                        job             = '0;
                        job.value       = data_in;
                        if (words_done)
                        begin
                            job.jtype        = JOB_FLUSH;
                            op_next          = OP_FLUSH;
                            need_drq_next    = 1'b0;
                            dummy_count_next = '0;
                            poll_count_next  = '0;
                            phase_next       = PH_DUMMY;
                        end
                        else
                        begin
                            job.jtype = JOB_PAIR;
                            job.kind  = KIND_WORD_WR;
                            job.kind2 = KIND_DATA_REQ;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (do_try)
            begin
                if (budget_hit)
                begin
                    phase_next = PH_IDLE;
                    job        = mk_single(KIND_DONE, PORT_NONE, 16'd0, 1'b0);
                end
                else
                begin
                    phase_next = PH_POLL;
                    job        = mk_single(KIND_BYTE_RD, PORT_CMD, 16'd0, 1'b0);
                end
            end

            if (do_poll_ok)
            begin
                word_count_next = '0;
                unique case (op_reg)
                    OP_INIT:
                    begin
                        phase_next = PH_IDWORDS;
                        job        = mk_single(KIND_WORD_RD, PORT_NONE, 16'd0, 1'b0);
                    end
                    OP_READ:
                    begin
                        phase_next = PH_RDWORDS;
                        job        = mk_single(KIND_WORD_RD, PORT_NONE, 16'd0, 1'b0);
                    end
                    OP_WRITE:
                    begin
                        phase_next = PH_WRWORDS;
                        job        = mk_single(KIND_DATA_REQ, PORT_NONE, 16'd0, 1'b0);
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        job        = mk_single(KIND_DONE, PORT_NONE, 16'd0, 1'b1);
                    end
                endcase
            end
        end

        job.ready = ready_flag_next;
    end

endmodule

### design/apls_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO LBA28 sequencer job queue
// A small first-in first-out store of job descriptors between the front
// part and the back part.
// ----------------------------------------------------------------------------
module apls_queue
    import apls_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  queue_ctl_t ctl_in,
    input  job_t       wr_job,
    output job_t       rd_job,
    output logic       full,
    output logic       empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t               store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = ctl_in.push && !full;
    assign do_pop  = ctl_in.pop && !empty;
    assign rd_job  = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### design/apls_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO LBA28 sequencer back part
// Expands each job into its run of result items, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module apls_back
    import apls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  job_t        q_job,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_kind,
    output logic [2:0]  out_port,
    output logic [15:0] out_value,
    output logic        out_ok,
    output logic        out_rdy_flag,
    output logic        out_last
);

    logic        cur_valid_reg, cur_valid_next;
    job_t        cur_job_reg, cur_job_next;
    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, port_reg;
    logic [15:0] value_reg;
    logic        ok_reg, rdy_reg, last_reg;

    logic        load;
    logic [2:0]  r_kind, r_port;
    logic [15:0] r_value;
    logic        r_ok;
    logic [2:0]  r_final;
    logic        r_last;

    always_comb
    begin
        r_kind  = KIND_BYTE_WR;
        r_port  = PORT_NONE;
        r_value = 16'd0;
        r_ok    = 1'b0;
        r_final = 3'd0;
        unique case (cur_job_reg.jtype)
            JOB_SINGLE:
            begin
                r_kind  = cur_job_reg.kind;
                r_port  = cur_job_reg.port;
                r_value = cur_job_reg.value;
                r_ok    = cur_job_reg.ok;
                r_final = 3'd0;
            end
            JOB_ISSUE:
            begin
                r_final = 3'd7;
                unique case (step_reg)
                    3'd0:
                    begin
                        r_port  = PORT_DRIVE;
                        r_value = {8'd0, DRIVE_BASE | {4'd0, cur_job_reg.lba[27:24]}};
                    end
                    3'd1:
                    begin
                        r_kind = KIND_DELAY;
                    end
                    3'd2:
                    begin
                        r_port  = PORT_COUNT;
                        r_value = {15'd0, cur_job_reg.ok};
                    end
                    3'd3:
                    begin
                        r_port  = PORT_LBA_LO;
                        r_value = {8'd0, cur_job_reg.lba[7:0]};
                    end
                    3'd4:
                    begin
                        r_port  = PORT_LBA_MID;
                        r_value = {8'd0, cur_job_reg.lba[15:8]};
                    end
                    3'd5:
                    begin
                        r_port  = PORT_LBA_HI;
                        r_value = {8'd0, cur_job_reg.lba[23:16]};
                    end
                    3'd6:
                    begin
                        r_port  = PORT_CMD;
                        r_value = cur_job_reg.value;
                    end
                    default:
                    begin
                        r_kind = KIND_BYTE_RD;
                        r_port = PORT_CMD;
                    end
                endcase
            end
            JOB_PAIR:
            begin
                r_final = 3'd1;
                if (step_reg == 3'd0)
                begin
                    r_kind  = cur_job_reg.kind;
                    r_value = cur_job_reg.value;
                end
                else
                begin
                    r_kind = cur_job_reg.kind2;
                    r_ok   = cur_job_reg.ok;
                end
            end
            default:
            begin
                r_final = 3'd3;
                unique case (step_reg)
                    3'd0:
                    begin
                        r_kind  = KIND_WORD_WR;
                        r_value = cur_job_reg.value;
                    end
                    3'd1:
                    begin
                        r_kind = KIND_DELAY;
                    end
                    3'd2:
                    begin
                        r_port  = PORT_CMD;
                        r_value = {8'd0, CMD_FLUSH};
                    end
                    default:
                    begin
                        r_kind = KIND_BYTE_RD;
                        r_port = PORT_CMD;
                    end
                endcase
            end
        endcase
        r_last = (step_reg == r_final);
    end

    assign load = cur_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop = !q_empty && (!cur_valid_reg || (load && r_last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = step_reg + 3'd1;
            if (r_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            cur_job_next   = q_job;
            step_next      = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg <= cur_job_next;
        if (load)
        begin
            kind_reg  <= r_kind;
            port_reg  <= r_port;
            value_reg <= r_value;
            ok_reg    <= r_ok;
            rdy_reg   <= cur_job_reg.ready;
            last_reg  <= r_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = kind_reg;
    assign out_port     = port_reg;
    assign out_value    = value_reg;
    assign out_ok       = ok_reg;
    assign out_rdy_flag = rdy_reg;
    assign out_last     = last_reg;

endmodule

### design/ata_pio_lba28_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO LBA28 sequencer core
// Host-side task-file sequencer: commands, bus replies and host words in,
// bus accesses, host words and completion reports out.
//
// Channel   Direction  Carries
// s_axis    in         action (tuser), lba and data_in (tdata)
// m_axis    out        kind (tuser), port_offset/value/success/ready_res
//                      (tdata), last (tlast)
// cfg       in         poll_budget write
//
// The front part takes one item per cycle while the job queue has room.
// Each job leaves the back part at one result per cycle unless m_axis stalls:
// one or two for most items, four for the end of a write, eight for a command
// start. Jobs pass through the job queue and the current-job register to the
// output stage. Reset clears the queue, the output stage and all protocol state.
// ----------------------------------------------------------------------------
module ata_pio_lba28_sequencer_core
    import apls_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [19:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // lba [27:0], data_in [43:28], zero [47:44]
    input  logic [47:0] s_axis_tdata,
    // action [2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // port_offset [2:0], value [18:3], success [19], ready_res [20], zero [23:21]
    output logic [23:0] m_axis_tdata,
    // kind [2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic       accept;
    logic       job_valid;
    job_t       job_in;
    job_t       job_out;
    queue_ctl_t qctl;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic [2:0]  o_port;
    logic [15:0] o_value;
    logic        o_ok;
    logic        o_rdy;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    apls_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .action    (s_axis_tuser),
        .lba       (s_axis_tdata[27:0]),
        .data_in   (s_axis_tdata[43:28]),
        .job_valid (job_valid),
        .job       (job_in)
    );

    always_comb
    begin
        qctl.push = accept && job_valid;
        qctl.pop  = q_pop;
    end

    apls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (qctl),
        .wr_job (job_in),
        .rd_job (job_out),
        .full   (q_full),
        .empty  (q_empty)
    );

    apls_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_job        (job_out),
        .q_pop        (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_kind     (m_axis_tuser),
        .out_port     (o_port),
        .out_value    (o_value),
        .out_ok       (o_ok),
        .out_rdy_flag (o_rdy),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, o_rdy, o_ok, o_value, o_port};

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
        else $error("completion report not marked as last");

    a_status_read_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_BYTE_RD) |-> m_axis_tlast)
        else $error("status read not marked as last");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.push |-> !q_full)
        else $error("job pushed into a full queue");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from an empty queue");

endmodule
